/* hw/rtl/nru_pkg.sv */
package nru_pkg;

  localparam int FRAMES     = 8;
  localparam int PAGE_BITS  = 16;
  localparam int FIELD_BITS = 8;
  localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W      = $clog2(FRAMES + 1);

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [2:0]            cls_t;
  typedef logic [FIELD_BITS-1:0] bits_t;

  // Class above every real class, so the first active frame always beats it.
  localparam cls_t CLS_NONE = 3'd4;

  // Search word that travels down the row of frame cells.
  typedef struct packed {
    logic  valid;
    page_t page;
    bits_t ref_sh;
    bits_t mod_sh;
    logic  hit;
    idx_t  hit_idx;
    cls_t  best_cls;
    idx_t  best_idx;
    page_t best_page;
    logic  best_filled;
  } search_t;

  // Write of a page into one frame cell.
  typedef struct packed {
    logic  en;
    idx_t  idx;
    page_t page;
  } wr_t;

  typedef struct packed {
    logic  hit;
    idx_t  frame;
    logic  ev_valid;
    page_t ev_page;
  } res_t;

endpackage

/* hw/rtl/nru_page_replacement_top.sv */
// Channel   Direction  Handshake             Word
// in        in         in_valid / in_stall   page_number, ref_bits, mod_bits
// out       out        out_valid / out_stall hit, frame_index, evicted_valid,
//                                            evicted_page
// cfg       in         cfg_valid / cfg_ready frames_in_use
//
// A reference walks the row of FRAMES frame cells, one cell per cycle, and is
// resolved from the register behind the last cell into the output register.
// No new word is taken while a reference is in the row or in the hold slot.
// The row holds one reference at a time. A stalled result stays in the output
// register while the next reference walks; if that one finishes first it goes
// to a hold slot and no new word is taken until the hold slot empties.
// Reset clears the fill count and the filled flags and sets the frame count to 8.
module nru_page_replacement_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] page_number,
  input  logic [7:0]  ref_bits,
  input  logic [7:0]  mod_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [2:0]  frame_index,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  frames_in_use
);

  logic [3:0]           frames_cfg;
  nru_pkg::cnt_t        n_active;
  nru_pkg::cnt_t        fill_count;
  nru_pkg::cnt_t        fill_count_next;
  nru_pkg::search_t     chain [nru_pkg::FRAMES+1];
  nru_pkg::search_t     tail;
  nru_pkg::wr_t         wr;
  nru_pkg::res_t        res;
  nru_pkg::res_t        out_q;
  nru_pkg::res_t        hold_q;
  logic                 hold_valid;
  logic [nru_pkg::FRAMES:0] flight_vec;
  logic                 busy;
  logic                 in_take;
  logic                 out_take;
  logic                 out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      frames_cfg <= frames_in_use;
    end
  end

  always_comb begin
    if (frames_cfg == 4'd0) begin
      n_active = nru_pkg::cnt_t'(1);
    end else if (32'(frames_cfg) > nru_pkg::FRAMES) begin
      n_active = nru_pkg::cnt_t'(nru_pkg::FRAMES);
    end else begin
      n_active = nru_pkg::cnt_t'(frames_cfg);
    end
  end

  always_comb begin
    for (int i = 0; i <= nru_pkg::FRAMES; i++) begin
      flight_vec[i] = chain[i].valid;
    end
  end

  assign busy     = (|flight_vec) || hold_valid;
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || out_take;

  // Entry register of the row.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else begin
      chain[0].valid       <= in_take;
      chain[0].page        <= nru_pkg::page_t'(page_number);
      chain[0].ref_sh      <= ref_bits;
      chain[0].mod_sh      <= mod_bits;
      chain[0].hit         <= 1'b0;
      chain[0].hit_idx     <= '0;
      chain[0].best_cls    <= nru_pkg::CLS_NONE;
      chain[0].best_idx    <= '0;
      chain[0].best_page   <= '0;
      chain[0].best_filled <= 1'b0;
    end
  end

  for (genvar g = 0; g < nru_pkg::FRAMES; g++) begin : g_cell
    nru_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .my_idx   (nru_pkg::idx_t'(g)),
      .n_active (n_active),
      .wr       (wr),
      .sin      (chain[g]),
      .sout     (chain[g+1])
    );
  end

  assign tail = chain[nru_pkg::FRAMES];

  // Resolve the reference once it leaves the last cell: a hit, a fill of the
  // next empty frame, or a replacement of the best-class victim.
  always_comb begin
    res             = '0;
    wr              = '0;
    fill_count_next = fill_count;
    if (tail.valid) begin
      if (tail.hit) begin
        res.hit   = 1'b1;
        res.frame = tail.hit_idx;
      end else if (fill_count < n_active) begin
        res.frame       = nru_pkg::idx_t'(fill_count);
        wr.en           = 1'b1;
        wr.idx          = nru_pkg::idx_t'(fill_count);
        wr.page         = tail.page;
        fill_count_next = fill_count + nru_pkg::cnt_t'(1);
      end else begin
        res.frame    = tail.best_idx;
        res.ev_valid = tail.best_filled;
        res.ev_page  = tail.best_filled ? tail.best_page : '0;
        wr.en        = 1'b1;
        wr.idx       = tail.best_idx;
        wr.page      = tail.page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (tail.valid) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        hold_valid <= 1'b1;
      end
    end else if (hold_valid && out_free) begin
      out_valid  <= 1'b1;
      hold_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        hold_q <= res;
      end
    end else if (hold_valid && out_free) begin
      out_q <= hold_q;
    end
  end

  assign hit           = out_q.hit;
  assign frame_index   = 3'(out_q.frame);
  assign evicted_valid = out_q.ev_valid;
  assign evicted_page  = 16'(out_q.ev_page);

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $countones({flight_vec, hold_valid}) <= 1)
    else $error("more than one reference in flight");

  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("hold slot full while output register is empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= nru_pkg::FRAMES)
    else $error("fill count beyond frame count");

  a_write_active: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (nru_pkg::cnt_t'(wr.idx) < n_active))
    else $error("write to a frame outside the active range");

  a_walk_length: assert property (@(posedge clk) disable iff (rst)
    in_take |-> ##(nru_pkg::FRAMES+1) tail.valid)
    else $error("reference did not leave the row on time");
`endif

endmodule

/* hw/rtl/nru_cell.sv */
module nru_cell (
  input  logic             clk,
  input  logic             rst,
  input  nru_pkg::idx_t    my_idx,
  input  nru_pkg::cnt_t    n_active,
  input  nru_pkg::wr_t     wr,
  input  nru_pkg::search_t sin,
  output nru_pkg::search_t sout
);

  nru_pkg::page_t   resident_page;
  logic             filled;
  logic             active;
  nru_pkg::cls_t    cls;
  nru_pkg::search_t sout_next;

  assign active = (nru_pkg::cnt_t'(my_idx) < n_active);
  assign cls    = {1'b0, sin.ref_sh[0], sin.mod_sh[0]};

  // Each cell looks at bit 0 of the flag vectors and shifts them on, so the
  // next cell finds its own flags in bit 0 and frames past the field read zero.
  always_comb begin
    sout_next        = sin;
    sout_next.ref_sh = sin.ref_sh >> 1;
    sout_next.mod_sh = sin.mod_sh >> 1;
    if (active && filled && !sin.hit && (resident_page == sin.page)) begin
      sout_next.hit     = 1'b1;
      sout_next.hit_idx = my_idx;
    end
    if (active && (cls < sin.best_cls)) begin
      sout_next.best_cls    = cls;
      sout_next.best_idx    = my_idx;
      sout_next.best_page   = resident_page;
      sout_next.best_filled = filled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sout.valid <= 1'b0;
    end else begin
      sout <= sout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (wr.en && (wr.idx == my_idx)) begin
      filled <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == my_idx)) begin
      resident_page <= wr.page;
    end
  end

endmodule

/* tb/nru_page_replacement_top_tb.sv */
module nru_page_replacement_top_tb;

  localparam int CLK_PERIOD = 12;
  localparam int DIR_N      = 22;
  localparam int POOL_N     = 12;
  localparam int PHASE_LEN  = 40;
  localparam int N_PHASES   = 11;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] page_number = '0;
  logic [7:0]  ref_bits = '0;
  logic [7:0]  mod_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [2:0]  frame_index;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  frames_in_use = 4'd8;

  nru_page_replacement_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .page_number(page_number),
    .ref_bits(ref_bits),
    .mod_bits(mod_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .frame_index(frame_index),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .frames_in_use(frames_in_use)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted frame table, kept in step with the block.
  nru_pkg::page_t frame_page [nru_pkg::FRAMES];
  logic           frame_full [nru_pkg::FRAMES];
  int             fill_cnt;
  logic [3:0]     frames_cfg;

  nru_pkg::res_t pending_results [$];
  int            err_cnt = 0;
  bit            quiet_tail = 1'b0;

  function automatic nru_pkg::res_t nru_lookup(input nru_pkg::page_t pg,
                                               input nru_pkg::bits_t rb,
                                               input nru_pkg::bits_t mb);
    nru_pkg::res_t r;
    int            n;
    nru_pkg::cls_t best;
    nru_pkg::cls_t c;
    r = '0;
    n = (frames_cfg == 0) ? 1 :
        (frames_cfg > nru_pkg::FRAMES) ? nru_pkg::FRAMES : int'(frames_cfg);
    for (int j = 0; j < n; j++) begin
      if (!r.hit && frame_full[j] && frame_page[j] == pg) begin
        r.hit = 1'b1;
        r.frame = nru_pkg::idx_t'(j);
      end
    end
    if (!r.hit) begin
      if (fill_cnt < n) begin
        r.frame = nru_pkg::idx_t'(fill_cnt);
        fill_cnt++;
      end else begin
        best = nru_pkg::CLS_NONE;
        for (int j = 0; j < n; j++) begin
          c = {1'b0, rb[j], mb[j]};
          if (c < best) begin
            best = c;
            r.frame = nru_pkg::idx_t'(j);
          end
        end
        if (frame_full[r.frame]) begin
          r.ev_valid = 1'b1;
          r.ev_page = frame_page[r.frame];
        end
      end
      frame_page[r.frame] = pg;
      frame_full[r.frame] = 1'b1;
    end
    return r;
  endfunction

  task automatic push_ref(input nru_pkg::page_t pg, input nru_pkg::bits_t rb,
                          input nru_pkg::bits_t mb, input bit typed,
                          input nru_pkg::res_t want);
    nru_pkg::res_t calc;
    @(negedge clk);
    in_valid <= 1'b1;
    page_number <= pg;
    ref_bits <= rb;
    mod_bits <= mb;
    do @(posedge clk); while (in_stall);
    calc = nru_lookup(pg, rb, mb);
    pending_results.push_back(typed ? want : calc);
  endtask

  task automatic sender_gap(input int n);
    repeat (n) @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_frames(input logic [3:0] v);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    frames_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    frames_cfg = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Result side: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin : check_out
    nru_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result word: hit=%0d frame=%0d ev=%0d page=%h",
                   hit, frame_index, evicted_valid, evicted_page);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit || frame_index !== want.frame ||
            evicted_valid !== want.ev_valid || evicted_page !== want.ev_page) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp hit=%0d frame=%0d ev=%0d page=%h, got %0d %0d %0d %h",
                     want.hit, want.frame, want.ev_valid, want.ev_page,
                     hit, frame_index, evicted_valid, evicted_page);
        end
      end
    end
  end

  // Receiver stalls in bursts, with free stretches between them.
  initial begin : out_side
    int n;
    forever begin
      n = $urandom_range(1, 30);
      repeat (n) @(negedge clk) out_stall <= 1'b0;
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk) out_stall <= 1'b1;
      end
    end
  end

  typedef struct {
    nru_pkg::page_t pg;
    nru_pkg::bits_t rb;
    nru_pkg::bits_t mb;
    bit             typed;
    nru_pkg::res_t  want;
  } dir_row_t;

  // Runs at the reset setting of eight frames: fill, hits, then victims of class 0, 1 and 3.
  dir_row_t dir_rows [DIR_N] = '{
    '{16'h0000, 8'hff, 8'hff, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000}},
    '{16'hffff, 8'h00, 8'h00, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000}},
    '{16'h0000, 8'h00, 8'h00, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000}},
    '{16'hffff, 8'hff, 8'hff, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000}},
    '{16'h0002, 8'ha5, 8'h5a, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000}},
    '{16'h0003, 8'ha5, 8'h5a, 1'b1, '{1'b0, 3'd3, 1'b0, 16'h0000}},
    '{16'h0004, 8'ha5, 8'h5a, 1'b1, '{1'b0, 3'd4, 1'b0, 16'h0000}},
    '{16'h0005, 8'ha5, 8'h5a, 1'b1, '{1'b0, 3'd5, 1'b0, 16'h0000}},
    '{16'h0006, 8'ha5, 8'h5a, 1'b1, '{1'b0, 3'd6, 1'b0, 16'h0000}},
    '{16'h0007, 8'ha5, 8'h5a, 1'b1, '{1'b0, 3'd7, 1'b0, 16'h0000}},
    '{16'h1234, 8'hff, 8'hff, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000}},
    '{16'h5555, 8'h00, 8'h00, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h1234}},
    '{16'haaaa, 8'h7f, 8'hff, 1'b1, '{1'b0, 3'd7, 1'b1, 16'h0007}},
    '{16'h8001, 8'h80, 8'h7f, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h5555}},
    '{16'haaaa, 8'h00, 8'h00, 1'b1, '{1'b1, 3'd7, 1'b0, 16'h0000}},
    '{16'h0006, 8'hff, 8'h00, 1'b1, '{1'b1, 3'd6, 1'b0, 16'h0000}},
    '{16'h7fff, 8'h0f, 8'hf0, 1'b1, '{1'b0, 3'd4, 1'b1, 16'h0004}},
    '{16'hc3c3, 8'h3c, 8'hc3, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h8001}},
    '{16'hffff, 8'h55, 8'haa, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000}},
    '{16'h0001, 8'h5a, 8'h3c, 1'b0, '0},
    '{16'h0000, 8'h12, 8'h34, 1'b0, '0},
    '{16'h0003, 8'h99, 8'h66, 1'b0, '0}
  };

  initial begin : stim
    logic [3:0] phase_cfg [N_PHASES] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2,
                                         4'd12, 4'd7, 4'd4, 4'd8};
    nru_pkg::page_t pool [POOL_N];
    nru_pkg::page_t pg;
    nru_pkg::bits_t rb;
    nru_pkg::bits_t mb;

    for (int i = 0; i < nru_pkg::FRAMES; i++) begin
      frame_page[i] = '0;
      frame_full[i] = 1'b0;
    end
    fill_cnt = 0;
    frames_cfg = 4'd8;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_ref(dir_rows[i].pg, dir_rows[i].rb, dir_rows[i].mb,
               dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      // The table is kept across a change of the frame count.
      set_frames(phase_cfg[p]);
      if (p == N_PHASES - 1)
        quiet_tail = 1'b1;
      foreach (pool[k])
        pool[k] = nru_pkg::page_t'($urandom);
      if (p % 3 == 0) begin
        pool[0] = '0;
        pool[1] = '1;
      end
      for (int i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(0, 3) != 0)
          pg = pool[$urandom_range(0, POOL_N - 1)];
        else
          pg = nru_pkg::page_t'($urandom);
        case ($urandom_range(0, 7))
          0: begin
            rb = '0;
            mb = '0;
          end
          1: begin
            rb = '1;
            mb = '1;
          end
          default: begin
            rb = nru_pkg::bits_t'($urandom);
            mb = nru_pkg::bits_t'($urandom);
          end
        endcase
        push_ref(pg, rb, mb, 1'b0, '0);
        // Once in the run the sender holds off until the block has drained.
        if (p == 4 && i == PHASE_LEN / 2)
          drain_results();
        else if (!quiet_tail && $urandom_range(0, 5) == 0)
          sender_gap($urandom_range(1, 18));
      end
    end

    drain_results();
    repeat (3 * (nru_pkg::FRAMES + 2)) @(posedge clk);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
